[design/sfr_pkg.sv]
// shared constants for the s.bus frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;
  localparam int FRAME_BYTES     = 25;
  localparam int ANALOG_CHANNELS = 16;
  localparam int ADDR_W          = 5;
  localparam int BYTE_W          = 8;
  localparam int IDX_W           = 5;
  localparam int VAL_W           = 12;
  localparam int CNT_W           = 32;

  localparam logic [BYTE_W-1:0] START_MARK = 8'h0F;
  localparam logic [BYTE_W-1:0] END_SYNC1  = 8'h00;
  localparam logic [BYTE_W-1:0] END_VOLT   = 8'h04;
  localparam logic [BYTE_W-1:0] END_GPS    = 8'h14;
  localparam logic [BYTE_W-1:0] END_SYNC2A = 8'h24;
  localparam logic [BYTE_W-1:0] END_SYNC2B = 8'h34;
  localparam logic [BYTE_W-1:0] LEAD_VOLT  = 8'h03;
  localparam logic [BYTE_W-1:0] LEAD_GPS   = 8'h13;

  localparam logic [ADDR_W-1:0] FLAGS_POS     = 5'd23;
  localparam logic [ADDR_W-1:0] LAST_POS      = 5'd24;
  localparam logic [ADDR_W-1:0] VOLT_SLOT_LEN = 5'd3;
  localparam logic [ADDR_W-1:0] GPS_SLOT_LEN  = 5'd24;

  localparam logic [VAL_W-1:0] VAL_OFFSET  = 12'd874;
  localparam logic [VAL_W-1:0] DIGITAL_LO  = 12'd998;
  localparam logic [VAL_W-1:0] DIGITAL_HI  = 12'd1998;
  localparam logic [IDX_W-1:0] MAX_CH_RST  = 5'd18;
endpackage
`default_nettype wire

[design/sfr_if.sv]
// valid/ready channel interfaces for the s.bus frame receiver
// depends on sfr_pkg
`timescale 1ns / 1ps
`default_nettype none
interface sfr_in_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] chan_limit;
  modport source (output valid, output chan_limit, input ready);
  modport sink   (input valid, input chan_limit, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] channel_index;
  logic [VAL_W-1:0] channel_value;
  logic             failsafe;
  logic             frame_lost;
  logic [CNT_W-1:0] drop_count;
  logic             last;
  modport source (output valid, output channel_index, output channel_value,
                  output failsafe, output frame_lost, output drop_count,
                  output last, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input failsafe, input frame_lost, input drop_count,
                  input last, output ready);
endinterface
`default_nettype wire

[design/sfr_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 25
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

[design/sbus_frame_receiver_core.sv]
// s.bus frame receiver: byte in, decoded channel items out
// depends on sfr_pkg, sfr_if and sfr_ram
//
// usage: rx_if takes one serial byte per item. res_if gives one item per
// reported channel of a good frame, last set on the final one. cfg_if writes
// chan_limit (reset 18), ready always high; write only while idle.
// the 25 frame bytes live in a ram with registered read data.
// a byte that does not complete a frame leaves rx ready high. a completed
// good frame first reads the flags byte, then for each analog channel makes
// three ram reads and a scale step, then takes one step per digital channel.
// a failed frame runs a scan for a later start byte, then a copy that moves
// the tail down.
// rx ready is high whenever no frame decode, scan or copy is running; the
// output register lets the next byte in while the final item waits.
// a stalled res_if holds the decode at the current channel.
// reset: desync, empty frame, drop count zero; no ram clearing needed.
`timescale 1ns / 1ps
`default_nettype none
module sbus_frame_receiver_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_cfg_if.sink   cfg_if,
  sfr_in_if.sink    rx_if,
  sfr_out_if.source res_if
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    S_DESYNC, S_START, S_SYNC1, S_SYNC2, S_VOLT, S_GPS
  } sync_e;

  typedef enum logic [2:0] {
    P_IDLE, P_FLAGS, P_CHAN, P_DIG, P_SCAN, P_COPY
  } phase_e;

  sync_e              sync_q;
  phase_e             phase_q;
  logic [ADDR_W-1:0]  fill_q;
  logic [BYTE_W-1:0]  byte0_q;
  logic [CNT_W-1:0]   drop_q;
  logic [IDX_W-1:0]   max_q;
  logic [BYTE_W-1:0]  flags_q;
  logic [3:0]         ch_q;
  logic [1:0]         k_q;
  logic               dig_q;
  logic [BYTE_W-1:0]  w0_q, w1_q;
  logic [ADDR_W-1:0]  scan_q, ra_q, found_q, cp_q;
  logic               rv_q;

  logic               res_valid_q, res_last_q, res_fs_q, res_lost_q;
  logic [IDX_W-1:0]   res_idx_q;
  logic [VAL_W-1:0]   res_val_q;
  logic [CNT_W-1:0]   res_drop_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  logic               acc, in_frame, in_slot, out_free;
  logic [BYTE_W-1:0]  b;
  logic [7:0]         bit_w;
  logic [ADDR_W-1:0]  pos, nf, n_w, cp_last, src;
  logic [1:0]         koff;
  logic [23:0]        w24, sh;
  logic [13:0]        v5;
  logic [VAL_W-1:0]   scaled;

  sfr_ram #(.WIDTH(BYTE_W), .DEPTH(FRAME_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx_if.ready  = (phase_q == P_IDLE);
  assign cfg_if.ready = 1'b1;
  assign acc      = rx_if.valid && rx_if.ready;
  assign b        = rx_if.rx_byte;
  assign in_frame = (sync_q == S_START) || (sync_q == S_SYNC1) || (sync_q == S_SYNC2);
  assign in_slot  = (sync_q == S_VOLT) || (sync_q == S_GPS);
  assign out_free = !res_valid_q || res_if.ready;
  assign nf       = fill_q + 5'd1;
  assign n_w      = (max_q > 5'(ANALOG_CHANNELS)) ? 5'(ANALOG_CHANNELS) : max_q;
  assign cp_last  = 5'(FRAME_BYTES) - found_q;
  assign src      = found_q + cp_q;

  // channel bit position and the three bytes that hold it
  assign bit_w  = {1'b0, ch_q, 3'b000} + {3'b000, ch_q, 1'b0} + {4'b0000, ch_q};
  assign pos    = 5'd1 + bit_w[7:3];
  assign koff   = (k_q == 2'd3) ? 2'd2 : k_q;
  assign w24    = {ram_rdata, w1_q, w0_q};
  assign sh     = w24 >> bit_w[2:0];
  assign v5     = {1'b0, sh[10:0], 2'b00} + {3'b000, sh[10:0]} + 14'd4;
  assign scaled = {1'b0, v5[13:3]} + VAL_OFFSET;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_q;
    ram_wdata = b;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (phase_q)
      P_IDLE: begin
        if (acc && (in_frame || in_slot)) begin
          ram_we = 1'b1;
        end else if (acc && sync_q == S_DESYNC && b == START_MARK) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end
      end
      P_FLAGS: begin
        ram_re    = (k_q == 2'd0);
        ram_raddr = FLAGS_POS;
      end
      P_CHAN: begin
        ram_re    = (k_q != 2'd3);
        ram_raddr = pos + {3'b000, koff};
      end
      P_DIG: ;
      P_SCAN: begin
        ram_re    = (scan_q <= LAST_POS);
        ram_raddr = scan_q;
      end
      P_COPY: begin
        ram_re    = (src <= LAST_POS);
        ram_raddr = src;
        ram_we    = (cp_q != '0);
        ram_waddr = cp_q - 5'd1;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= S_DESYNC;
      phase_q     <= P_IDLE;
      fill_q      <= '0;
      drop_q      <= '0;
      max_q       <= MAX_CH_RST;
      res_valid_q <= 1'b0;
      k_q         <= '0;
      ch_q        <= '0;
      dig_q       <= 1'b0;
      rv_q        <= 1'b0;
      scan_q      <= '0;
      cp_q        <= '0;
    end else begin
      if (cfg_if.valid) begin
        max_q <= cfg_if.chan_limit;
      end
      if (res_if.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (phase_q)
        P_IDLE: begin
          if (acc) begin
            if (sync_q == S_DESYNC) begin
              if (b == START_MARK) begin
                sync_q  <= S_START;
                byte0_q <= b;
                fill_q  <= 5'd1;
              end
            end else if (in_frame) begin
              if (fill_q == '0) begin
                byte0_q <= b;
              end
              if (nf == 5'(FRAME_BYTES)) begin
                if (byte0_q != START_MARK) begin
                  drop_q  <= drop_q + 32'd1;
                  sync_q  <= S_DESYNC;
                  phase_q <= P_SCAN;
                  scan_q  <= 5'd1;
                  rv_q    <= 1'b0;
                end else begin
                  case (b) inside
                    END_SYNC1:              sync_q <= S_SYNC1;
                    END_VOLT:               sync_q <= S_VOLT;
                    END_GPS:                sync_q <= S_GPS;
                    END_SYNC2A, END_SYNC2B: sync_q <= S_SYNC2;
                    default:                sync_q <= S_DESYNC;
                  endcase
                  if (b == END_SYNC1 || b == END_VOLT || b == END_GPS ||
                      b == END_SYNC2A || b == END_SYNC2B) begin
                    fill_q <= '0;
                    k_q    <= '0;
                    ch_q   <= '0;
                    if (max_q != '0) begin
                      phase_q <= P_FLAGS;
                    end
                  end else begin
                    phase_q <= P_SCAN;
                    scan_q  <= 5'd1;
                    rv_q    <= 1'b0;
                  end
                end
              end else begin
                fill_q <= nf;
              end
            end else if (in_slot) begin
              if (fill_q == '0) begin
                byte0_q <= b;
              end
              fill_q <= nf;
              // a slot that opens with a start byte is really a frame
              if (nf == 5'd1 && b == START_MARK) begin
                sync_q <= S_SYNC2;
              end
              if (nf >= ((sync_q == S_VOLT) ? VOLT_SLOT_LEN : GPS_SLOT_LEN)) begin
                if (byte0_q == ((sync_q == S_VOLT) ? LEAD_VOLT : LEAD_GPS)) begin
                  fill_q <= '0;
                end else begin
                  sync_q <= S_DESYNC;
                  drop_q <= drop_q + 32'd1;
                end
              end
            end
          end
        end
        P_FLAGS: begin
          if (k_q == 2'd0) begin
            k_q <= 2'd1;
          end else begin
            flags_q <= ram_rdata;
            k_q     <= '0;
            phase_q <= P_CHAN;
          end
        end
        P_CHAN: begin
          case (k_q)
            2'd0: k_q <= 2'd1;
            2'd1: begin
              w0_q <= ram_rdata;
              k_q  <= 2'd2;
            end
            2'd2: begin
              w1_q <= ram_rdata;
              k_q  <= 2'd3;
            end
            default: begin
              if (out_free) begin
                res_valid_q <= 1'b1;
                res_idx_q   <= {1'b0, ch_q};
                res_val_q   <= scaled;
                res_fs_q    <= flags_q[3];
                res_lost_q  <= flags_q[3] | flags_q[2];
                res_drop_q  <= drop_q;
                res_last_q  <= ({1'b0, ch_q} == n_w - 5'd1) && (max_q <= 5'd17);
                k_q         <= '0;
                if ({1'b0, ch_q} == n_w - 5'd1) begin
                  if (max_q > 5'd17) begin
                    phase_q <= P_DIG;
                    dig_q   <= 1'b0;
                  end else begin
                    phase_q <= P_IDLE;
                  end
                end else begin
                  ch_q <= ch_q + 4'd1;
                end
              end
            end
          endcase
        end
        P_DIG: begin
          if (out_free) begin
            res_valid_q <= 1'b1;
            res_idx_q   <= 5'(ANALOG_CHANNELS) + {4'b0000, dig_q};
            res_val_q   <= flags_q[dig_q] ? DIGITAL_HI : DIGITAL_LO;
            res_fs_q    <= flags_q[3];
            res_lost_q  <= flags_q[3] | flags_q[2];
            res_drop_q  <= drop_q;
            res_last_q  <= dig_q;
            dig_q       <= 1'b1;
            if (dig_q) begin
              phase_q <= P_IDLE;
            end
          end
        end
        P_SCAN: begin
          if (scan_q <= LAST_POS) begin
            scan_q <= scan_q + 5'd1;
          end
          rv_q <= (scan_q <= LAST_POS);
          ra_q <= scan_q;
          if (rv_q) begin
            if (ram_rdata == START_MARK) begin
              found_q <= ra_q;
              cp_q    <= '0;
              phase_q <= P_COPY;
            end else if (ra_q == LAST_POS) begin
              fill_q  <= '0;
              phase_q <= P_IDLE;
            end
          end
        end
        P_COPY: begin
          cp_q <= cp_q + 5'd1;
          if (cp_q == cp_last) begin
            fill_q  <= cp_last;
            sync_q  <= S_START;
            byte0_q <= START_MARK;
            phase_q <= P_IDLE;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  assign res_if.valid         = res_valid_q;
  assign res_if.channel_index = res_idx_q;
  assign res_if.channel_value = res_val_q;
  assign res_if.failsafe      = res_fs_q;
  assign res_if.frame_lost    = res_lost_q;
  assign res_if.drop_count    = res_drop_q;
  assign res_if.last          = res_last_q;

  a_fill_below_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 5'(FRAME_BYTES))
    else $error("fill count reached frame length");

  a_copy_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_COPY) |-> (found_q != '0))
    else $error("copy without a found start byte");

  a_chan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_CHAN) |-> ({1'b0, ch_q} < n_w))
    else $error("channel counter beyond reported count");
endmodule
`default_nettype wire
